@@ hw/rtl/pmap_pkg.sv @@
// ----------------------------------------------------------------------------
// Page table mapper package
// Shared field types, control word layout, codes and the microprogram ROM
// of the page table mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package pmap_pkg;

    localparam int FRAME_W    = 40;
    localparam int VPN_W      = 36;
    localparam int ENTRY_W    = 64;
    localparam int IDX_W      = 9;
    localparam int ENTRIES    = 512;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 40;

    localparam logic [COUNT_W-1:0] POOL_COUNT_RESET = 7'd64;
    localparam logic [1:0]         LEAF_LEVEL       = 2'd3;
    localparam logic [IDX_W-1:0]   ZCNT_LAST        = IDX_W'(ENTRIES - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE  = 1'b0,
        CFG_POOL_COUNT = 1'b1
    } cfg_index_e;

    typedef enum logic [1:0] {
        STAT_MAPPED    = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_OUTSIDE   = 2'd2,
        STAT_SKIPPED   = 2'd3
    } status_e;

    typedef struct packed {
        logic [FRAME_W-1:0] root_frame;
        logic [VPN_W-1:0]   virt_page;
        logic [FRAME_W-1:0] phys_frame;
        logic               want_write;
        logic               want_user;
        logic               want_noexec;
        logic               last_page;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ENTRY_W-1:0] leaf_entry;
        logic [1:0]         tables_made;
        logic               run_done;
    } rsp_t;

    // Program steps of the walk.
    typedef enum logic [3:0] {
        STEP_IDLE    = 4'd0,
        STEP_CHECK   = 4'd1,
        STEP_ROOT    = 4'd2,
        STEP_READ    = 4'd3,
        STEP_TEST    = 4'd4,
        STEP_ALLOC   = 4'd5,
        STEP_ZERO    = 4'd6,
        STEP_LINK    = 4'd7,
        STEP_FOLLOW  = 4'd8,
        STEP_OUTSIDE = 4'd9,
        STEP_LEAF    = 4'd10,
        STEP_EXHAUST = 4'd11,
        STEP_SKIP    = 4'd12,
        STEP_DONE    = 4'd13
    } step_t;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_ROOT   = 4'd1,
        OP_READ   = 4'd2,
        OP_ZERO   = 4'd3,
        OP_LINK   = 4'd4,
        OP_FOLLOW = 4'd5,
        OP_LEAF   = 4'd6,
        OP_STATUS = 4'd7,
        OP_REPORT = 4'd8
    } op_e;

    typedef enum logic [3:0] {
        COND_ALWAYS     = 4'd0,
        COND_NEVER      = 4'd1,
        COND_NO_GO      = 4'd2,
        COND_RUN_FAILED = 4'd3,
        COND_ROOT_OUT   = 4'd4,
        COND_AT_LEAF    = 4'd5,
        COND_PRESENT    = 4'd6,
        COND_POOL_FULL  = 4'd7,
        COND_ZERO_MORE  = 4'd8,
        COND_ENTRY_IN   = 4'd9
    } cond_e;

    typedef struct packed {
        op_e     op;
        cond_e   cond;
        step_t   target;
        status_e stat;
    } ucode_t;

    typedef struct packed {
        logic run_failed;
        logic root_out;
        logic at_leaf;
        logic present;
        logic pool_full;
        logic zero_more;
        logic entry_in;
    } flags_t;

    // Microprogram: a taken condition jumps to the target, otherwise the
    // step counter advances by one.
    function automatic ucode_t ucode_word(input step_t step);
        ucode_t w;
        case (step)
            STEP_IDLE:    w = '{OP_NONE,   COND_NO_GO,      STEP_IDLE,    STAT_MAPPED};
            STEP_CHECK:   w = '{OP_NONE,   COND_RUN_FAILED, STEP_SKIP,    STAT_MAPPED};
            STEP_ROOT:    w = '{OP_ROOT,   COND_ROOT_OUT,   STEP_OUTSIDE, STAT_MAPPED};
            STEP_READ:    w = '{OP_READ,   COND_AT_LEAF,    STEP_LEAF,    STAT_MAPPED};
            STEP_TEST:    w = '{OP_NONE,   COND_PRESENT,    STEP_FOLLOW,  STAT_MAPPED};
            STEP_ALLOC:   w = '{OP_NONE,   COND_POOL_FULL,  STEP_EXHAUST, STAT_MAPPED};
            STEP_ZERO:    w = '{OP_ZERO,   COND_ZERO_MORE,  STEP_ZERO,    STAT_MAPPED};
            STEP_LINK:    w = '{OP_LINK,   COND_ALWAYS,     STEP_READ,    STAT_MAPPED};
            STEP_FOLLOW:  w = '{OP_FOLLOW, COND_ENTRY_IN,   STEP_READ,    STAT_MAPPED};
            STEP_OUTSIDE: w = '{OP_STATUS, COND_ALWAYS,     STEP_DONE,    STAT_OUTSIDE};
            STEP_LEAF:    w = '{OP_LEAF,   COND_ALWAYS,     STEP_DONE,    STAT_MAPPED};
            STEP_EXHAUST: w = '{OP_STATUS, COND_ALWAYS,     STEP_DONE,    STAT_EXHAUSTED};
            STEP_SKIP:    w = '{OP_STATUS, COND_NEVER,      STEP_IDLE,    STAT_SKIPPED};
            STEP_DONE:    w = '{OP_REPORT, COND_ALWAYS,     STEP_IDLE,    STAT_MAPPED};
            default:      w = '{OP_NONE,   COND_ALWAYS,     STEP_IDLE,    STAT_MAPPED};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pmap_sequencer.sv @@
// ----------------------------------------------------------------------------
// Page table mapper sequencer
// Step counter over the microprogram ROM with conditional jumps on the
// datapath flags.
// ----------------------------------------------------------------------------
`default_nettype none

module pmap_sequencer
    import pmap_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   go,
    input  wire flags_t flags,
    output ucode_t      ctl,
    output logic        idle
);

    step_t upc_reg;
    step_t upc_next;
    logic  taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    always_comb
    begin
        ctl = ucode_word(upc_reg);
        case (ctl.cond)
            COND_ALWAYS:     taken = 1'b1;
            COND_NEVER:      taken = 1'b0;
            COND_NO_GO:      taken = !go;
            COND_RUN_FAILED: taken = flags.run_failed;
            COND_ROOT_OUT:   taken = flags.root_out;
            COND_AT_LEAF:    taken = flags.at_leaf;
            COND_PRESENT:    taken = flags.present;
            COND_POOL_FULL:  taken = flags.pool_full;
            COND_ZERO_MORE:  taken = flags.zero_more;
            COND_ENTRY_IN:   taken = flags.entry_in;
            default:         taken = 1'b1;
        endcase
        upc_next = taken ? ctl.target : step_t'(upc_reg + 1'b1);
        idle     = (upc_reg == STEP_IDLE);
    end

endmodule

`default_nettype wire

@@ hw/rtl/pmap_datapath.sv @@
// ----------------------------------------------------------------------------
// Page table mapper datapath
// Table store, walk registers, bump allocator, configuration registers and
// the result register; the walk is driven by the sequencer's control word.
// ----------------------------------------------------------------------------
`default_nettype none

module pmap_datapath
    import pmap_pkg::*;
#(
    parameter int POOL_PAGES = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  accept,
    input  wire req_t                  req,
    input  wire ucode_t                ctl,
    output flags_t                     flags,
    output logic                       clearing,
    output logic                       done,
    output rsp_t                       rsp
);

    localparam int PAGE_W      = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int CNT_W       = $clog2(POOL_PAGES + 1);
    localparam int ADDR_W      = PAGE_W + IDX_W;
    localparam int STORE_WORDS = POOL_PAGES * ENTRIES;
    localparam logic [ADDR_W-1:0]  LAST_ADDR  = ADDR_W'(STORE_WORDS - 1);
    localparam logic [FRAME_W-1:0] POOL_LIMIT = FRAME_W'(POOL_PAGES);

    logic [ENTRY_W-1:0] store_mem [0:STORE_WORDS-1];

    // Configuration.
    logic [FRAME_W-1:0] base_reg;
    logic [COUNT_W-1:0] count_reg;

    // Walk state.
    req_t               req_reg,       req_next;
    logic [PAGE_W-1:0]  page_reg,      page_next;
    logic [1:0]         level_reg,     level_next;
    logic [1:0]         made_reg,      made_next;
    status_e            status_reg,    status_next;
    logic [ENTRY_W-1:0] leaf_reg,      leaf_next;
    logic [IDX_W-1:0]   zcnt_reg,      zcnt_next;
    logic [CNT_W-1:0]   next_free_reg, next_free_next;
    logic               run_failed_reg, run_failed_next;
    logic               clearing_reg,  clearing_next;
    logic [ADDR_W-1:0]  clr_addr_reg,  clr_addr_next;
    rsp_t               rsp_reg,       rsp_next;
    logic               done_reg,      done_next;
    logic [ENTRY_W-1:0] entry_reg;

    logic [FRAME_W-1:0] count_ext;
    logic [FRAME_W-1:0] usable;
    logic [FRAME_W-1:0] free_ext;
    logic [FRAME_W-1:0] root_off;
    logic [FRAME_W-1:0] ent_off;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] link_word;
    logic [ENTRY_W-1:0] leaf_word;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            count_reg <= POOL_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POOL_BASE:  base_reg  <= cfg_data[FRAME_W-1:0];
                CFG_POOL_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        count_ext = FRAME_W'(count_reg);
        usable    = (count_ext < POOL_LIMIT) ? count_ext : POOL_LIMIT;
        free_ext  = FRAME_W'(next_free_reg);
        // Pool membership is tested on the frame offset, modulo 2^40.
        root_off  = req_reg.root_frame - base_reg;
        ent_off   = entry_reg[51:12] - base_reg;
        case (level_reg)
            2'd0:    idx = req_reg.virt_page[35:27];
            2'd1:    idx = req_reg.virt_page[26:18];
            2'd2:    idx = req_reg.virt_page[17:9];
            default: idx = req_reg.virt_page[8:0];
        endcase
        link_word = {12'd0, base_reg + free_ext, 9'd0, 3'b111};
        leaf_word = {req_reg.want_noexec, 11'd0, req_reg.phys_frame, 9'd0,
                     req_reg.want_user, req_reg.want_write, 1'b1};

        flags.run_failed = run_failed_reg;
        flags.root_out   = !(root_off < usable);
        flags.at_leaf    = (level_reg == LEAF_LEVEL);
        flags.present    = entry_reg[0];
        flags.pool_full  = (free_ext >= usable);
        flags.zero_more  = (zcnt_reg != ZCNT_LAST);
        flags.entry_in   = (ent_off < usable);
    end

    always_comb
    begin
        req_next        = req_reg;
        page_next       = page_reg;
        level_next      = level_reg;
        made_next       = made_reg;
        status_next     = status_reg;
        leaf_next       = leaf_reg;
        zcnt_next       = zcnt_reg;
        next_free_next  = next_free_reg;
        run_failed_next = run_failed_reg;
        rsp_next        = rsp_reg;
        done_next       = 1'b0;
        clearing_next   = clearing_reg && (clr_addr_reg != LAST_ADDR);
        clr_addr_next   = clearing_reg ? clr_addr_reg + 1'b1 : clr_addr_reg;

        if (accept)
        begin
            req_next    = req;
            level_next  = '0;
            made_next   = '0;
            leaf_next   = '0;
            status_next = STAT_MAPPED;
        end

        case (ctl.op)
            OP_ROOT:
            begin
                page_next = root_off[PAGE_W-1:0];
            end
            OP_ZERO:
            begin
                zcnt_next = zcnt_reg + 1'b1;
            end
            OP_LINK:
            begin
                page_next      = next_free_reg[PAGE_W-1:0];
                next_free_next = next_free_reg + 1'b1;
                made_next      = made_reg + 1'b1;
                level_next     = level_reg + 1'b1;
            end
            OP_FOLLOW:
            begin
                page_next  = ent_off[PAGE_W-1:0];
                level_next = level_reg + 1'b1;
            end
            OP_LEAF:
            begin
                leaf_next   = leaf_word;
                status_next = ctl.stat;
            end
            OP_STATUS:
            begin
                status_next = ctl.stat;
            end
            OP_REPORT:
            begin
                rsp_next.status      = status_reg;
                rsp_next.leaf_entry  = leaf_reg;
                rsp_next.tables_made = made_reg;
                rsp_next.run_done    = req_reg.last_page;
                done_next            = 1'b1;
                // The last request of a run always clears the failure mark.
                run_failed_next = (run_failed_reg || (status_reg != STAT_MAPPED))
                                  && !req_reg.last_page;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= '0;
            made_reg       <= '0;
            status_reg     <= STAT_MAPPED;
            zcnt_reg       <= '0;
            next_free_reg  <= '0;
            run_failed_reg <= 1'b0;
            clearing_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            level_reg      <= level_next;
            made_reg       <= made_next;
            status_reg     <= status_next;
            zcnt_reg       <= zcnt_next;
            next_free_reg  <= next_free_next;
            run_failed_reg <= run_failed_next;
            clearing_reg   <= clearing_next;
            clr_addr_reg   <= clr_addr_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        page_reg <= page_next;
        leaf_reg <= leaf_next;
        rsp_reg  <= rsp_next;
    end

    // One store port: the reset sweep, table zeroing, links and leaves write,
    // the walk reads.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = {page_reg, idx};
        mem_wdata = '0;
        if (clearing_reg)
        begin
            mem_we   = 1'b1;
            mem_addr = clr_addr_reg;
        end
        else
        begin
            case (ctl.op)
                OP_ZERO:
                begin
                    mem_we   = 1'b1;
                    mem_addr = {next_free_reg[PAGE_W-1:0], zcnt_reg};
                end
                OP_LINK:
                begin
                    mem_we    = 1'b1;
                    mem_wdata = link_word;
                end
                OP_LEAF:
                begin
                    mem_we    = 1'b1;
                    mem_wdata = leaf_word;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= mem_wdata;
        end
        if (ctl.op == OP_READ)
        begin
            entry_reg <= store_mem[mem_addr];
        end
    end

    assign clearing = clearing_reg;
    assign done     = done_reg;
    assign rsp      = rsp_reg;

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_link_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_LINK) |-> !flags.pool_full)
        else $error("table linked with the pool exhausted");

    a_leaf_level: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_LEAF) |-> (level_reg == LEAF_LEVEL))
        else $error("leaf written above the last level");

    a_leaf_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ((rsp_reg.status == STAT_MAPPED) == rsp_reg.leaf_entry[0]))
        else $error("leaf entry does not agree with the status");

endmodule

`default_nettype wire

@@ hw/rtl/page_table_mapper.sv @@
// ----------------------------------------------------------------------------
// Page table mapper
// Maps one virtual page per request into a four-level page table held in an
// on-chip table pool, allocating and zeroing missing tables on the way.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. The
// result appears on rsp, marked by done for exactly one cycle; the receiver
// must take it then, as there is no back-pressure. The next request may be
// issued in the cycle in which done is high.
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// block is idle; a write takes effect at the edge it is presented.
// After reset the table store is swept to zero, one entry per cycle, over
// all POOL_PAGES * 512 entries (32768 at the default size); busy stays high
// until the sweep ends.
// A request whose tables already exist makes four dependent reads of the
// single store port, the first three each with a test and a pointer follow,
// then the leaf write. A new request is taken only once the previous one has
// reported. Every table that has to be created adds its 512 zeroing writes
// and the link write. A request skipped after an earlier failure in its run
// returns without reading the store.
// ----------------------------------------------------------------------------
`default_nettype none

module page_table_mapper
    import pmap_pkg::*;
#(
    parameter int POOL_PAGES = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire req_t                  req,
    output logic                       done,
    output rsp_t                       rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ucode_t ctl;
    flags_t flags;
    logic   seq_idle;
    logic   clearing;
    logic   accept;

    assign busy   = !seq_idle || clearing;
    assign accept = start && !busy;

    pmap_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (accept),
        .flags (flags),
        .ctl   (ctl),
        .idle  (seq_idle)
    );

    pmap_datapath #(
        .POOL_PAGES (POOL_PAGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .req       (req),
        .ctl       (ctl),
        .flags     (flags),
        .clearing  (clearing),
        .done      (done),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Page table mapper testbench
// Drives mapping requests into the page table mapper and checks every result
// against the result given for a typed directed row, else against a shadow
// of the table pool doing the same four-level walk. A short directed table
// covers the corner cases; randomised runs under several pool settings follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import pmap_pkg::*;

    localparam int TB_POOL_PAGES = 64;
    localparam int POOL_WORDS    = TB_POOL_PAGES * ENTRIES;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 225;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES   = 40;
    localparam int STALL_LIMIT   = 150000;
    localparam int SEEN_MAX      = 48;

    localparam bit [3:0] FL_WRITE  = 4'b1000;
    localparam bit [3:0] FL_USER   = 4'b0100;
    localparam bit [3:0] FL_NOEXEC = 4'b0010;
    localparam bit [3:0] FL_LAST   = 4'b0001;

    localparam bit [39:0] FRAME_MAX = 40'hFF_FFFF_FFFF;
    localparam bit [35:0] VPN_MAX   = 36'hF_FFFF_FFFF;

    typedef struct {
        bit        is_cfg;
        req_t      r;
        bit [39:0] base;
        bit [6:0]  count;
        bit        typed;
        rsp_t      want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    req_t                  req;
    logic                  done;
    rsp_t                  rsp;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow of the table pool and of the mapper's own state.
    bit [63:0] shadow_tables [POOL_WORDS];
    bit [6:0]  alloc_next;
    bit        run_broken;
    bit [39:0] pool_base;
    bit [6:0]  pool_count;

    rsp_t      maps_in_flight [$];
    bit [35:0] seen_vpns [$];
    rsp_t      head;
    int        fail_count;
    int        stall_cycles;

    plan_row_t plan [24];
    rsp_t      outcome;
    req_t      r;
    bit [39:0] nb;
    bit [39:0] home_root;
    bit [6:0]  nc;
    bit        steady;
    int        i;
    int        p;
    int        n;
    int        gap;

    page_table_mapper #(
        .POOL_PAGES (TB_POOL_PAGES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned usable_pages();
        return (pool_count < TB_POOL_PAGES) ? pool_count : TB_POOL_PAGES;
    endfunction

    function automatic bit pool_page_of(input bit [39:0] frame, output int unsigned pg);
        bit [39:0] off;
        off = frame - pool_base;
        pg  = off[6:0];
        return off < usable_pages();
    endfunction

    // Walks levels 4 to 2, allocating missing tables, then writes the leaf.
    function automatic status_e walk_tables(input req_t q, output bit [1:0] made,
                                            output bit [63:0] leaf);
        int unsigned pg;
        int unsigned np;
        int unsigned slot;
        int          lvl;
        int          k;
        bit [63:0]   ent;
        made = 2'd0;
        leaf = 64'd0;
        if (!pool_page_of(q.root_frame, pg))
            return STAT_OUTSIDE;
        for (lvl = 0; lvl < 3; lvl++)
        begin
            slot = pg * ENTRIES + q.virt_page[27 - 9 * lvl +: 9];
            ent  = shadow_tables[slot];
            if (!ent[0])
            begin
                if (alloc_next >= usable_pages())
                    return STAT_EXHAUSTED;
                np = alloc_next;
                alloc_next++;
                for (k = 0; k < ENTRIES; k++)
                    shadow_tables[np * ENTRIES + k] = 64'd0;
                shadow_tables[slot] = {12'h000, 40'(pool_base + np), 12'h007};
                made++;
                pg = np;
            end
            else if (!pool_page_of(ent[51:12], pg))
            begin
                return STAT_OUTSIDE;
            end
        end
        leaf = {q.want_noexec, 11'h000, q.phys_frame, 9'h000,
                q.want_user, q.want_write, 1'b1};
        shadow_tables[pg * ENTRIES + q.virt_page[8:0]] = leaf;
        return STAT_MAPPED;
    endfunction

    function automatic rsp_t map_request(input req_t q);
        rsp_t      e;
        status_e   s;
        bit [1:0]  made;
        bit [63:0] leaf;
        made = 2'd0;
        leaf = 64'd0;
        if (run_broken)
        begin
            s = STAT_SKIPPED;
        end
        else
        begin
            s = walk_tables(q, made, leaf);
            if (s != STAT_MAPPED)
                run_broken = 1'b1;
        end
        // The last request of a run always clears the failure, whatever its status.
        if (q.last_page)
            run_broken = 1'b0;
        e.status      = s;
        e.leaf_entry  = leaf;
        e.tables_made = made;
        e.run_done    = q.last_page;
        return e;
    endfunction

    function automatic plan_row_t rq(input bit [39:0] root, input bit [35:0] vp,
                                     input bit [39:0] phys, input bit [3:0] fl);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.r      = '{root, vp, phys, fl[3], fl[2], fl[1], fl[0]};
        row.base   = 40'd0;
        row.count  = 7'd0;
        row.typed  = 1'b0;
        row.want   = '0;
        return row;
    endfunction

    function automatic plan_row_t with_result(input plan_row_t row, input status_e s,
                                              input bit [63:0] leaf, input bit [1:0] made);
        row.typed = 1'b1;
        row.want  = '{s, leaf, made, row.r.last_page};
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input bit [39:0] base, input bit [6:0] count);
        plan_row_t row;
        row        = rq(40'd0, 36'd0, 40'd0, 4'd0);
        row.is_cfg = 1'b1;
        row.base   = base;
        row.count  = count;
        return row;
    endfunction

    function automatic req_t random_request(input bit [39:0] root_home);
        req_t        q;
        bit [63:0]   noise;
        int unsigned pick;
        noise = rand64();
        pick  = $urandom_range(0, 99);
        if (seen_vpns.size() == 0 || pick >= 93)
        begin
            q.virt_page = 36'(rand64());
        end
        else
        begin
            // Mostly stay under tables that are already built, so walks go deep.
            q.virt_page = seen_vpns[$urandom_range(0, seen_vpns.size() - 1)];
            if (pick < 50)
                q.virt_page[8:0] = noise[8:0];
            else if (pick < 75)
                q.virt_page[17:0] = noise[17:0];
            else if (pick < 85)
                q.virt_page[26:0] = noise[26:0];
        end
        pick = $urandom_range(0, 99);
        if (pick < 88)
            q.root_frame = root_home;
        else if (pick < 95)
            q.root_frame = pool_base + 40'($urandom_range(0, 70));
        else
            q.root_frame = 40'(rand64());
        q.phys_frame = 40'(rand64());
        {q.want_write, q.want_user, q.want_noexec} = noise[63:61];
        q.last_page = ($urandom_range(0, 3) == 0);
        return q;
    endfunction

    function automatic int gap_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 60);
    endfunction

    task automatic issue_request(input req_t q, input bit typed, input rsp_t want,
                                 output rsp_t predicted);
        req   <= q;
        start <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        predicted = map_request(q);
        maps_in_flight.push_back(typed ? want : predicted);
    endtask

    task automatic drain_requests();
        start <= 1'b0;
        while (maps_in_flight.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_pool(input bit [39:0] base, input bit [6:0] count);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POOL_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= CFG_POOL_COUNT;
        cfg_data  <= {33'(rand64()), count};
        @(posedge clk);
        cfg_we     <= 1'b0;
        pool_base  = base;
        pool_count = count;
    endtask

    task automatic compare_field(input string what, input bit [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (maps_in_flight.size() == 0)
            begin
                $display("%0t: result with none outstanding, expected none, got %h",
                         $time, rsp);
                fail_count++;
            end
            else
            begin
                head = maps_in_flight.pop_front();
                compare_field("status", head.status, rsp.status);
                compare_field("leaf_entry", head.leaf_entry, rsp.leaf_entry);
                compare_field("tables_made", head.tables_made, rsp.tables_made);
                compare_field("run_done", head.run_done, rsp.run_done);
            end
        end
    end

    // Covers the table sweep after reset as well as the slowest allocating walk.
    always @(posedge clk)
    begin
        if (!rst_n || (start === 1'b1 && busy === 1'b0) || done === 1'b1)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("tb: done, errors");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_POOL_BASE;
        cfg_data     = '0;
        fail_count   = 0;
        stall_cycles = 0;
        alloc_next   = 7'd0;
        run_broken   = 1'b0;
        pool_base    = 40'd0;
        pool_count   = POOL_COUNT_RESET;

        plan = '{
            with_result(rq(40'd64, 36'd0, 40'd0, 4'd0), STAT_OUTSIDE, 64'd0, 2'd0),
            with_result(rq(40'd0, 36'd0, 40'd0, FL_LAST), STAT_SKIPPED, 64'd0, 2'd0),
            // The allocator hands out the root's own page here.
            rq(40'd0, 36'd0, 40'd0, FL_LAST),
            with_result(rq(40'd0, VPN_MAX, FRAME_MAX, FL_WRITE | FL_USER | FL_NOEXEC | FL_LAST),
                        STAT_MAPPED, 64'h800F_FFFF_FFFF_F007, 2'd3),
            rq(40'd0, VPN_MAX, 40'h12_3456_789A, FL_LAST),
            rq(40'd0, 36'hF_FFFF_FF00, 40'd1, FL_WRITE),
            rq(40'd0, 36'hF_FFFC_01FF, 40'h80_0000_0000, FL_USER | FL_LAST),
            rq(40'd0, 36'd1, 40'h00_0000_F000, FL_NOEXEC | FL_LAST),
            cfg_row(40'd0, 7'd6),
            with_result(rq(40'd0, 36'h4_0000_0000, 40'h3C_3C3C_3C3C, 4'd0),
                        STAT_EXHAUSTED, 64'd0, 2'd1),
            with_result(rq(40'd0, VPN_MAX, 40'h55_5555_5555, FL_WRITE),
                        STAT_SKIPPED, 64'd0, 2'd0),
            with_result(rq(40'd0, 36'd0, 40'h55_5555_5555, FL_LAST),
                        STAT_SKIPPED, 64'd0, 2'd0),
            with_result(rq(40'd0, 36'h4_0000_0000, 40'd1, FL_LAST),
                        STAT_EXHAUSTED, 64'd0, 2'd0),
            cfg_row(40'd0, 7'd2),
            // A present entry now points past the end of the shrunken pool.
            with_result(rq(40'd0, VPN_MAX, 40'd2, FL_LAST), STAT_OUTSIDE, 64'd0, 2'd0),
            cfg_row(40'd0, 7'd0),
            with_result(rq(40'd0, 36'd0, 40'd0, FL_LAST), STAT_OUTSIDE, 64'd0, 2'd0),
            cfg_row(FRAME_MAX, 7'd64),
            rq(FRAME_MAX, 36'd0, 40'd7, FL_LAST),
            rq(40'd0, VPN_MAX, 40'd8, FL_LAST),
            rq(FRAME_MAX, 36'd0, 40'd9, FL_WRITE | FL_LAST),
            cfg_row(40'd0, 7'd127),
            with_result(rq(40'd64, 36'd0, 40'd0, FL_LAST), STAT_OUTSIDE, 64'd0, 2'd0),
            rq(40'd63, 36'h5_5555_5555, 40'hAA_AAAA_AAAA, FL_WRITE | FL_NOEXEC | FL_LAST)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < $size(plan); i++)
        begin
            if (plan[i].is_cfg)
            begin
                drain_requests();
                program_pool(plan[i].base, plan[i].count);
            end
            else
            begin
                issue_request(plan[i].r, plan[i].typed, plan[i].want, outcome);
            end
        end

        for (p = 0; p < PHASES; p++)
        begin
            nb = 40'd0;
            nc = 7'd64;
            case (p)
                1: nc = 7'd127;
                2: nc = 7'($urandom_range(1, 64));
                3:
                begin
                    nb = 40'(rand64());
                    nc = 7'($urandom_range(0, 127));
                end
                4: nb = FRAME_MAX;
                5: nc = 7'd1;
                default: nc = 7'd64;
            endcase
            drain_requests();
            program_pool(nb, nc);
            home_root = nb + ((p == 6) ? 40'($urandom_range(0, 7)) : 40'd0);
            steady    = (p == 1 || p == 5);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                r = random_request(home_root);
                issue_request(r, 1'b0, '0, outcome);
                if (outcome.status == STAT_MAPPED)
                begin
                    seen_vpns.push_back(r.virt_page);
                    if (seen_vpns.size() > SEEN_MAX)
                        void'(seen_vpns.pop_front());
                end
                if ($urandom_range(0, 99) < 2)
                begin
                    drain_requests();
                end
                else
                begin
                    gap = steady ? 0 : gap_len();
                    if (gap > 0)
                    begin
                        start <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
            end
        end

        drain_requests();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/pmap_pkg.sv
hw/rtl/pmap_sequencer.sv
hw/rtl/pmap_datapath.sv
hw/rtl/page_table_mapper.sv
sim/tb.sv
